// File: sv/cma_pkg.sv
// Package for the centred moving average filter.
// Queue entry type and shared constants; no dependencies.
`default_nettype none
package cma_pkg;

  localparam int ID_W    = 16;
  localparam int JOINT_W = 5;
  localparam int COORD_W = 32;
  localparam int HALF_W  = 4;
  // widest ring slot index, for a half width of up to 63
  localparam int SLOT_W  = 7;

  typedef struct packed {
    logic [ID_W-1:0]           record_id;
    logic [JOINT_W-1:0]        joint;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      fin;
    logic [HALF_W-1:0]         h;
    logic [SLOT_W-1:0]         slot;
    logic                      emit_main;
    logic                      avg;
    logic [HALF_W-1:0]         start;
  } cma_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cma_qstat_t;

endpackage
`default_nettype wire

// File: sv/centered_moving_average_filter_top.sv
// Top level of the centred moving average filter.
// Instantiates cma_front, cma_queue and cma_back; depends on cma_pkg.
`default_nettype none
// Takes one joint sample per transaction and returns the record h places
// back, averaged over 2h+1 records (truncated toward zero) or passed raw at
// stream edges; a final-record sample also flushes that joint's pending
// records. An averaged result takes one history read per window entry, then
// a one-bit-per-cycle divider over the SW+32-bit sum (SW = bits of a ring
// slot; SW+32 is 37 for the defaults). A two-entry queue lets up to two
// samples wait ahead of the executor. The history memories need no clearing
// after reset. The executor pops a new sample only once it is idle.
module centered_moving_average_filter_top #(
  parameter int JOINTS   = 20,
  parameter int MAX_HALF = 15
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data,       // half_width
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // record_id[15:0], joint[20:16], x_in[52:21], y_in[84:53], z_in[116:85]
  input  wire logic [119:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,   // final_record
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_record_id[15:0], out_joint[20:16], x_out[52:21], y_out[84:53],
  // z_out[116:85]
  output logic [119:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // averaged
  output logic              m_axis_tlast    // run_last
);
  import cma_pkg::*;

  cma_entry_t push_entry;
  cma_entry_t pop_entry;
  cma_qstat_t qstat;
  logic       push;
  logic       pop;

  cma_front #(.JOINTS(JOINTS), .MAX_HALF(MAX_HALF)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .record_id    (s_axis_tdata[15:0]),
    .joint        (s_axis_tdata[20:16]),
    .x_in         (s_axis_tdata[52:21]),
    .y_in         (s_axis_tdata[84:53]),
    .z_in         (s_axis_tdata[116:85]),
    .final_record (s_axis_tlast),
    .qstat        (qstat),
    .push         (push),
    .entry        (push_entry)
  );

  cma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .stat      (qstat)
  );

  cma_back #(.JOINTS(JOINTS), .MAX_HALF(MAX_HALF)) u_back (
    .clk           (clk),
    .rst           (rst),
    .entry         (pop_entry),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_record_id (m_axis_tdata[15:0]),
    .out_joint     (m_axis_tdata[20:16]),
    .x_out         (m_axis_tdata[52:21]),
    .y_out         (m_axis_tdata[84:53]),
    .z_out         (m_axis_tdata[116:85]),
    .averaged      (m_axis_tuser),
    .run_last      (m_axis_tlast)
  );

  assign m_axis_tdata[119:117] = 3'd0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("queue read while empty");

  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> !pop)
    else $error("executor took two queue entries back to back");

endmodule
`default_nettype wire

// File: sv/cma_queue.sv
// Two-entry queue between the classifier and the executor.
// Depends on cma_pkg.
`default_nettype none
module cma_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire cma_pkg::cma_entry_t push_data,
  input  wire logic               pop,
  output cma_pkg::cma_entry_t     pop_data,
  output cma_pkg::cma_qstat_t     stat
);
  import cma_pkg::*;

  cma_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

endmodule
`default_nettype wire

// File: sv/cma_front.sv
// Classifier: accepts joint items, holds the half width and ring position,
// decides which results each item causes. Depends on cma_pkg.
`default_nettype none
module cma_front #(
  parameter int JOINTS   = 20,
  parameter int MAX_HALF = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cma_pkg::HALF_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cma_pkg::ID_W-1:0]    record_id,
  input  wire logic [cma_pkg::JOINT_W-1:0] joint,
  input  wire logic [cma_pkg::COORD_W-1:0] x_in,
  input  wire logic [cma_pkg::COORD_W-1:0] y_in,
  input  wire logic [cma_pkg::COORD_W-1:0] z_in,
  input  wire logic                        final_record,
  input  wire cma_pkg::cma_qstat_t         qstat,
  output logic                             push,
  output cma_pkg::cma_entry_t              entry
);
  import cma_pkg::*;

  localparam int RING = 2 * MAX_HALF + 1;
  localparam int SW   = $clog2(RING);

  logic [HALF_W-1:0] half_width;
  logic [SW-1:0]     ring_slot;
  logic [15:0]       records_seen;
  logic [HALF_W-1:0] h;
  logic              accept;
  logic              closing;

  assign cfg_ready = 1'b1;
  assign in_ready  = !qstat.full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (int'(joint) < JOINTS);
  assign closing   = push && (int'(joint) == JOINTS - 1);
  assign h = (int'(half_width) > MAX_HALF) ? HALF_W'(MAX_HALF) : half_width;

  always_comb begin
    entry.record_id = record_id;
    entry.joint     = joint;
    entry.x         = x_in;
    entry.y         = y_in;
    entry.z         = z_in;
    entry.fin       = final_record;
    entry.h         = h;
    entry.slot      = SLOT_W'(ring_slot);
    entry.emit_main = records_seen >= 16'(h);
    entry.avg       = records_seen >= {11'd0, h, 1'b0};
    entry.start     = entry.emit_main ? h : (records_seen[HALF_W-1:0] + HALF_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= HALF_W'(1);
      ring_slot    <= '0;
      records_seen <= '0;
    end else begin
      if (cfg_valid) half_width <= cfg_data;
      if (closing) begin
        if (final_record) begin
          ring_slot    <= '0;
          records_seen <= '0;
        end else begin
          ring_slot <= (int'(ring_slot) == RING - 1) ? '0 : ring_slot + SW'(1);
          if (records_seen != 16'hFFFF) records_seen <= records_seen + 16'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/cma_back.sv
// Executor: stores samples in the history memories, sums the window,
// divides by the window length and emits results. Depends on cma_pkg.
`default_nettype none
module cma_back #(
  parameter int JOINTS   = 20,
  parameter int MAX_HALF = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cma_pkg::cma_entry_t    entry,
  input  wire cma_pkg::cma_qstat_t    qstat,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [cma_pkg::ID_W-1:0]    out_record_id,
  output logic [cma_pkg::JOINT_W-1:0] out_joint,
  output logic [cma_pkg::COORD_W-1:0] x_out,
  output logic [cma_pkg::COORD_W-1:0] y_out,
  output logic [cma_pkg::COORD_W-1:0] z_out,
  output logic                        averaged,
  output logic                        run_last
);
  import cma_pkg::*;

  localparam int RING  = 2 * MAX_HALF + 1;
  localparam int SW    = $clog2(RING);
  localparam int DEPTH = RING * JOINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = COORD_W + SW;
  localparam int DCW   = $clog2(SUMW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_SUML  = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_AVG   = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_ROUT  = 4'd8;

  logic [COORD_W-1:0] xm [DEPTH];
  logic [COORD_W-1:0] ym [DEPTH];
  logic [COORD_W-1:0] zm [DEPTH];
  logic [ID_W-1:0]    idm [RING];

  cma_entry_t          e;
  logic [3:0]          st;
  logic [SW-1:0]       rd_slot;
  logic [SW-1:0]       iss;
  logic                rd_v;
  logic [HALF_W-1:0]   rem_cnt;
  logic                in_flush;
  logic [COORD_W-1:0]  q [3];
  logic [ID_W-1:0]     id_q;
  logic signed [SUMW-1:0] acc [3];
  logic [SUMW-1:0]     quo [3];
  logic [SW-1:0]       rem [3];
  logic                neg [3];
  logic [DCW-1:0]      dcnt;

  logic [SW-1:0]  e_slot;
  logic [SW-1:0]  cs;
  logic [SW-1:0]  flush_slot;
  logic [SW:0]    divisor;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           ren;
  logic           ofree;
  logic           emit_now;
  logic           has_flush;
  logic [SW:0]    tr [3];

  function automatic logic [SW-1:0] back_slot(input logic [SW-1:0] s,
                                               input logic [HALF_W:0] d);
    logic [SW+HALF_W:0] sw;
    logic [SW+HALF_W:0] dw;
    begin
      sw = (SW + HALF_W + 1)'(s);
      dw = (SW + HALF_W + 1)'(d);
      back_slot = (sw >= dw) ? SW'(sw - dw) : SW'(sw + (SW + HALF_W + 1)'(RING) - dw);
    end
  endfunction

  assign e_slot     = e.slot[SW-1:0];
  assign cs         = back_slot(e_slot, {1'b0, e.h});
  assign flush_slot = back_slot(e_slot, {1'b0, e.start} - (HALF_W + 1)'(1));
  assign divisor    = (SW + 1)'({e.h, 1'b1});
  assign wr_addr    = AW'(AW'(e_slot) * AW'(JOINTS) + AW'(e.joint));
  assign rd_addr    = AW'(AW'(rd_slot) * AW'(JOINTS) + AW'(e.joint));
  assign ren        = st == S_SUM || st == S_SUML || st == S_RRD;
  assign ofree      = !out_valid || out_ready;
  assign emit_now   = (st == S_AVG || st == S_ROUT) && ofree;
  assign has_flush  = e.fin && (e.start != '0);
  assign pop        = st == S_IDLE && !qstat.empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr[i] = {rem[i], quo[i][SUMW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_WR) begin
      xm[wr_addr] <= e.x;
      ym[wr_addr] <= e.y;
      zm[wr_addr] <= e.z;
      idm[e_slot] <= e.record_id;
    end
    if (ren) begin
      q[0] <= xm[rd_addr];
      q[1] <= ym[rd_addr];
      q[2] <= zm[rd_addr];
      id_q <= idm[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) e <= entry;
    rd_v <= st == S_SUM;
    case (st)
      S_WR: begin
        for (int i = 0; i < 3; i++) acc[i] <= '0;
      end
      S_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= acc[i][SUMW-1];
          quo[i] <= acc[i][SUMW-1] ? SUMW'(-acc[i]) : SUMW'(acc[i]);
          rem[i] <= '0;
        end
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (tr[i] >= divisor) begin
            rem[i] <= SW'(tr[i] - divisor);
            quo[i] <= {quo[i][SUMW-2:0], 1'b1};
          end else begin
            rem[i] <= tr[i][SW-1:0];
            quo[i] <= {quo[i][SUMW-2:0], 1'b0};
          end
        end
      end
      default: begin
        if (rd_v) begin
          for (int i = 0; i < 3; i++) begin
            acc[i] <= acc[i] + SUMW'($signed(q[i]));
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      in_flush  <= 1'b0;
      rd_slot   <= '0;
      iss       <= '0;
      rem_cnt   <= '0;
      dcnt      <= '0;
    end else begin
      if (out_ready && !emit_now) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (pop) st <= S_WR;
        end
        S_WR: begin
          if (e.emit_main) begin
            in_flush <= 1'b0;
            if (e.avg) begin
              rd_slot <= e_slot;
              iss     <= '0;
              st      <= S_SUM;
            end else begin
              rd_slot <= cs;
              st      <= S_RRD;
            end
          end else if (e.fin) begin
            rd_slot  <= flush_slot;
            rem_cnt  <= e.start;
            in_flush <= 1'b1;
            st       <= S_RRD;
          end else begin
            st <= S_IDLE;
          end
        end
        S_SUM: begin
          if (iss == SW'({e.h, 1'b0})) begin
            rd_slot <= cs;
            st      <= S_SUML;
          end else begin
            rd_slot <= (rd_slot == '0) ? SW'(RING - 1) : rd_slot - SW'(1);
            iss     <= iss + SW'(1);
          end
        end
        S_SUML: st <= S_DINIT;
        S_DINIT: begin
          dcnt <= DCW'(SUMW - 1);
          st   <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == '0) st <= S_AVG;
          else dcnt <= dcnt - DCW'(1);
        end
        S_AVG, S_ROUT: begin
          if (ofree) begin
            out_valid     <= 1'b1;
            out_record_id <= id_q;
            out_joint     <= e.joint;
            if (st == S_AVG) begin
              x_out    <= neg[0] ? COORD_W'(-quo[0]) : COORD_W'(quo[0]);
              y_out    <= neg[1] ? COORD_W'(-quo[1]) : COORD_W'(quo[1]);
              z_out    <= neg[2] ? COORD_W'(-quo[2]) : COORD_W'(quo[2]);
              averaged <= 1'b1;
            end else begin
              x_out    <= q[0];
              y_out    <= q[1];
              z_out    <= q[2];
              averaged <= 1'b0;
            end
            if (st == S_ROUT && in_flush) begin
              run_last <= rem_cnt == HALF_W'(1);
              if (rem_cnt == HALF_W'(1)) begin
                st <= S_IDLE;
              end else begin
                rem_cnt <= rem_cnt - HALF_W'(1);
                rd_slot <= (int'(rd_slot) == RING - 1) ? '0 : rd_slot + SW'(1);
                st      <= S_RRD;
              end
            end else begin
              run_last <= !has_flush;
              if (has_flush) begin
                rd_slot  <= flush_slot;
                rem_cnt  <= e.start;
                in_flush <= 1'b1;
                st       <= S_RRD;
              end else begin
                st <= S_IDLE;
              end
            end
          end
        end
        S_RRD: st <= S_ROUT;
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/centered_moving_average_filter_top_tb.sv
// Testbench for centered_moving_average_filter_top: a queue-fed stream driver, a self-checking
// monitor with its own window-average predictor, and half-width changes between streams.
// Depends on cma_pkg and the filter RTL.
`timescale 1ns / 100ps
module centered_moving_average_filter_top_tb;
  import cma_pkg::*;

  localparam int NJ = 20;
  localparam int MAXH = 15;
  localparam int RING = 2 * MAXH + 1;

  typedef struct {
    logic [15:0] rec_id;
    logic [4:0]  jnt;
    logic [31:0] x, y, z;
    logic        fin;
  } sample_t;

  typedef struct {
    logic [15:0] rec_id;
    logic [4:0]  jnt;
    logic [31:0] x, y, z;
    logic        avg;
    logic        last;
  } joint_out_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [3:0] cfg_data = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [119:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [119:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;

  centered_moving_average_filter_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  sample_t pending[$];
  sample_t cur;
  joint_out_t expected_out[$];
  int errors = 0;
  bit quiet = 0;
  bit long_hold = 0;
  bit long_done = 0;

  // predictor state
  logic [31:0] hx[RING][NJ], hy[RING][NJ], hz[RING][NJ];
  logic [15:0] hid[RING];
  int slot_p = 0, seen_p = 0, half_p = 1;

  function automatic int back(int d);
    return (slot_p + RING - d) % RING;
  endfunction

  function automatic void push_raw(int s, int j);
    joint_out_t o;
    o.rec_id = hid[s]; o.jnt = j[4:0];
    o.x = hx[s][j]; o.y = hy[s][j]; o.z = hz[s][j];
    o.avg = 0; o.last = 0;
    expected_out.push_back(o);
  endfunction

  function automatic void predict_window(sample_t it);
    int j, n, h, cnt, start;
    longint sx, sy, sz, dv;
    joint_out_t o;
    j = it.jnt; n = seen_p; h = half_p; cnt = 0;
    if (j >= NJ) return;
    hid[slot_p] = it.rec_id;
    hx[slot_p][j] = it.x; hy[slot_p][j] = it.y; hz[slot_p][j] = it.z;
    if (n >= h) begin
      if (n >= 2 * h) begin
        sx = 0; sy = 0; sz = 0; dv = 2 * h + 1;
        for (int d = 0; d <= 2 * h; d++) begin
          sx += longint'(signed'(hx[back(d)][j]));
          sy += longint'(signed'(hy[back(d)][j]));
          sz += longint'(signed'(hz[back(d)][j]));
        end
        o.rec_id = hid[back(h)]; o.jnt = j[4:0];
        o.x = 32'(sx / dv); o.y = 32'(sy / dv); o.z = 32'(sz / dv);
        o.avg = 1; o.last = 0;
        expected_out.push_back(o);
      end else push_raw(back(h), j);
      cnt++;
    end
    if (it.fin) begin
      start = (n >= h) ? h : n + 1;
      for (int d = start; d > 0; d--) begin
        push_raw(back(d - 1), j);
        cnt++;
      end
    end
    if (cnt > 0) expected_out[$].last = 1;
    if (j == NJ - 1) begin
      if (it.fin) begin
        slot_p = 0; seen_p = 0;
      end else begin
        slot_p = (slot_p + 1) % RING;
        if (seen_p < 65535) seen_p++;
      end
    end
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    int w;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_window(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_axis_tvalid <= 0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          s_axis_tdata <= {3'b000, cur.z, cur.y, cur.x, cur.jnt, cur.rec_id};
          s_axis_tlast <= cur.fin;
          s_axis_tvalid <= 1;
          w = quiet ? 0 : $urandom_range(0, 10);
          gap <= w;
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  int hold = 0;
  always @(posedge clk) begin
    joint_out_t e;
    int w;
    if (rst) begin
      m_axis_tready <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected transaction: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_out.pop_front();
        if (m_axis_tdata[15:0] !== e.rec_id) begin
          $error("out_record_id: expected %0d, actual %0d", e.rec_id, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[20:16] !== e.jnt) begin
          $error("out_joint: expected %0d, actual %0d", e.jnt, m_axis_tdata[20:16]);
          errors++;
        end
        if (m_axis_tdata[52:21] !== e.x) begin
          $error("x_out: expected %h, actual %h", e.x, m_axis_tdata[52:21]);
          errors++;
        end
        if (m_axis_tdata[84:53] !== e.y) begin
          $error("y_out: expected %h, actual %h", e.y, m_axis_tdata[84:53]);
          errors++;
        end
        if (m_axis_tdata[116:85] !== e.z) begin
          $error("z_out: expected %h, actual %h", e.z, m_axis_tdata[116:85]);
          errors++;
        end
        if (m_axis_tuser !== e.avg) begin
          $error("averaged: expected %0d, actual %0d", e.avg, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("run_last: expected %0d, actual %0d", e.last, m_axis_tlast);
          errors++;
        end
      end
      if (long_hold && !long_done) begin
        w = 400;
        long_done <= 1;
      end else w = quiet ? 0 : $urandom_range(0, 10);
      hold <= w;
      m_axis_tready <= (w == 0);
    end else if (hold > 0) begin
      hold <= hold - 1;
      m_axis_tready <= (hold == 1);
    end else begin
      m_axis_tready <= 1;
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= 5000) begin
      $display("Mismatches found");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_stream(int recs, bit noisy);
    sample_t it;
    logic [15:0] rid;
    for (int r = 0; r < recs; r++) begin
      rid = 16'($urandom);
      for (int j = 0; j < NJ; j++) begin
        if (noisy && $urandom_range(0, 15) == 0) begin
          it.rec_id = 16'($urandom); it.jnt = 5'($urandom_range(NJ, 31));
          it.x = $urandom; it.y = $urandom; it.z = $urandom; it.fin = 1'($urandom);
          pending.push_back(it);
        end
        it.rec_id = rid; it.jnt = 5'(j);
        it.x = coord(); it.y = coord(); it.z = coord();
        it.fin = (r == recs - 1);
        pending.push_back(it);
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || s_axis_tvalid || expected_out.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_half(logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 0;
    half_p = v;
  endtask

  initial begin
    int hs[7];
    int recs;
    sample_t it;
    hs = '{0, 1, 2, 15, 1, 0, 6};
    repeat (9) @(posedge clk);
    rst <= 0;
    // single short record at reset width: flushed raw, plus extreme fields
    it.rec_id = 16'hffff; it.jnt = 5'd31; it.x = 32'h8000_0000; it.y = 32'h7fff_ffff;
    it.z = 0; it.fin = 1;
    pending.push_back(it);
    for (int j = 0; j < NJ; j++) begin
      it.rec_id = (j == NJ - 1) ? 16'h0000 : 16'hffff; it.jnt = 5'(j);
      it.x = (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      it.y = ~it.x; it.z = coord(); it.fin = 1;
      pending.push_back(it);
    end
    settle();
    for (int p = 0; p < 7; p++) begin
      set_half(4'(hs[p]));
      quiet = (p == 4);
      if (hs[p] <= 2) recs = 2 * hs[p] + 1;
      else recs = (hs[p] == 15) ? 1 : 2;
      if (p == 2) long_hold <= 1;
      add_stream(recs, 1);
      settle();
    end
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
sv/cma_pkg.sv
sv/cma_queue.sv
sv/cma_front.sv
sv/cma_back.sv
sv/centered_moving_average_filter_top.sv
test/centered_moving_average_filter_top_tb.sv
